[sv/integral_image_stream_core_assert.svh]
// assertion macros for the integral image core
`ifndef INTEGRAL_IMAGE_STREAM_CORE_ASSERT_SVH
`define INTEGRAL_IMAGE_STREAM_CORE_ASSERT_SVH

`ifndef SYNTH
`define IIS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iis assertion failed");
`define IIS_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("iis forbidden condition seen");
`else
`define IIS_ASSERT(label, clk, rst_n, prop)
`define IIS_NEVER(label, clk, rst_n, prop)
`endif

`endif

[sv/iis_pkg.sv]
`timescale 1ns / 1ps

package iis_pkg;

    localparam int SUM_W       = 32;
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 16;
    localparam int ROW_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    typedef struct packed {
        logic first_row;
        logic frame_last;
    } iis_flags_t;

endpackage

[sv/iis_ram.sv]
`timescale 1ns / 1ps

module iis_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/iis_front.sv]
`timescale 1ns / 1ps
`include "integral_image_stream_core_assert.svh"

module iis_front
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16,
    parameter int COL_W      = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    output logic [SUM_W-1:0]      push_sum,
    output logic [COL_W-1:0]      push_col,
    output iis_flags_t            push_flags
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [SUM_W-1:0]    rowsum_reg, rowsum_next;
    logic [SUM_W-1:0]    width_last;
    logic [HEIGHT_W-1:0] height_last;
    logic [SUM_W-1:0]    sum_new;
    logic                last_col;
    logic                last_row;

    // last column and row index, zero sizes act as one, widths beyond MAX_WIDTH as MAX_WIDTH
    always_comb
    begin
        if (width_reg == '0)
        begin
            width_last = '0;
        end
        else if (SUM_W'(width_reg) > SUM_W'(MAX_WIDTH))
        begin
            width_last = SUM_W'(MAX_WIDTH) - SUM_W'(1);
        end
        else
        begin
            width_last = SUM_W'(width_reg) - SUM_W'(1);
        end
        height_last = (height_reg == '0) ? '0 : height_reg - HEIGHT_W'(1);
    end

    assign last_col = SUM_W'(col_reg) >= width_last;
    assign last_row = row_reg >= height_last;
    assign sum_new  = rowsum_reg + SUM_W'(pixel_value);

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        rowsum_next = rowsum_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next    = '0;
                rowsum_next = '0;
                row_next    = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next    = col_reg + COL_W'(1);
                rowsum_next = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            rowsum_reg <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data[WIDTH_W-1:0];
            end
            if (cfg_write && cfg_index == REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data[HEIGHT_W-1:0];
            end
            col_reg    <= col_next;
            row_reg    <= row_next;
            rowsum_reg <= rowsum_next;
        end
    end

    assign push_sum              = sum_new;
    assign push_col              = col_reg;
    assign push_flags.first_row  = (row_reg == '0);
    assign push_flags.frame_last = last_col && last_row;

    `IIS_ASSERT(a_row_end_clears, clk, rst_n,
        accept && last_col |=> col_reg == '0 && rowsum_reg == '0)

endmodule

[sv/iis_queue.sv]
`timescale 1ns / 1ps
`include "integral_image_stream_core_assert.svh"

module iis_queue #(
    parameter int DATA_W = 45,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              ready,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign ready      = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `IIS_NEVER(a_no_overflow, clk, rst_n, push && !ready)
    `IIS_NEVER(a_count_range, clk, rst_n, count_reg > CNT_W'(DEPTH))

endmodule

[sv/iis_back.sv]
`timescale 1ns / 1ps
`include "integral_image_stream_core_assert.svh"

module iis_back
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W     = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  logic [SUM_W-1:0] head_sum,
    input  logic [COL_W-1:0] head_col,
    input  iis_flags_t       head_flags,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [SUM_W-1:0] integral_sum,
    output logic             frame_last
);

    logic             s1_valid_reg, s1_valid_next;
    logic [SUM_W-1:0] s1_rowsum_reg;
    logic [COL_W-1:0] s1_col_reg;
    iis_flags_t       s1_flags_reg;
    logic             fwd_valid_reg;
    logic [SUM_W-1:0] fwd_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] out_sum_reg;
    logic             out_last_reg;
    logic [SUM_W-1:0] line_rdata;
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] sum;
    logic             out_advance;
    logic             s1_advance;

    // line store: previous row's integral values, one entry per column
    iis_ram #(
        .DATA_W (SUM_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line (
        .clk     (clk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (sum),
        .rd_en   (pop),
        .rd_addr (head_col),
        .rd_data (line_rdata)
    );

    assign out_advance = !out_valid_reg || !result_stall;
    assign s1_advance  = s1_valid_reg && out_advance;
    assign pop         = head_valid && (!s1_valid_reg || out_advance);

    // above: zero on the first row, bypass when the item ahead writes the column just read
    always_comb
    begin
        if (s1_flags_reg.first_row)
        begin
            above = '0;
        end
        else if (fwd_valid_reg)
        begin
            above = fwd_data_reg;
        end
        else
        begin
            above = line_rdata;
        end
    end

    assign sum = s1_rowsum_reg + above;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_rowsum_reg <= head_sum;
            s1_col_reg    <= head_col;
            s1_flags_reg  <= head_flags;
            fwd_valid_reg <= s1_advance && (s1_col_reg == head_col);
            fwd_data_reg  <= sum;
        end
        if (s1_advance)
        begin
            out_sum_reg  <= sum;
            out_last_reg <= s1_flags_reg.frame_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign integral_sum = out_sum_reg;
    assign frame_last   = out_last_reg;

    `IIS_ASSERT(a_s1_holds, clk, rst_n,
        s1_valid_reg && !out_advance |=> s1_valid_reg && $stable(s1_col_reg))
    `IIS_ASSERT(a_result_kept, clk, rst_n,
        out_valid_reg && result_stall |=> out_valid_reg && $stable(out_sum_reg))

endmodule

[sv/integral_image_stream_core.sv]
`timescale 1ns / 1ps

// Streaming integral image: pixels of one plane arrive in raster order and each
// transfer yields the 32-bit wrapping sum of all pixels above and left of it,
// itself included, with frame_last set on the last pixel of the frame. One pixel
// is taken every clock while the result side keeps up; a result passes the queue
// slot, the s1 registers (with the line store read) and the output register. The
// rate is set by the single line store of MAX_WIDTH words, read once and written
// once per pixel; a four-entry queue between the counter front end and the summing
// back end absorbs result stalls. Width and height must be written only while the
// core is idle; the core does not enforce this. Widths of zero or beyond MAX_WIDTH
// act as one and MAX_WIDTH, a height of zero acts as one.

module integral_image_stream_core
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [SUM_W-1:0]      integral_sum,
    output logic                  frame_last
);

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int FLAG_W  = $bits(iis_flags_t);
    localparam int ENTRY_W = SUM_W + COL_W + FLAG_W;

    logic               accept;
    logic               q_ready;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_head;
    logic [SUM_W-1:0]   push_sum;
    logic [COL_W-1:0]   push_col;
    iis_flags_t         push_flags;
    logic [SUM_W-1:0]   head_sum;
    logic [COL_W-1:0]   head_col;
    iis_flags_t         head_flags;

    assign pixel_stall = !q_ready;
    assign accept      = pixel_valid && q_ready;

    iis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .pixel_value (pixel_value),
        .push_sum    (push_sum),
        .push_col    (push_col),
        .push_flags  (push_flags)
    );

    iis_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  ({push_sum, push_col, push_flags}),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign head_sum   = q_head[ENTRY_W-1 -: SUM_W];
    assign head_col   = q_head[FLAG_W +: COL_W];
    assign head_flags = iis_flags_t'(q_head[FLAG_W-1:0]);

    iis_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_valid),
        .head_sum     (head_sum),
        .head_col     (head_col),
        .head_flags   (head_flags),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .integral_sum (integral_sum),
        .frame_last   (frame_last)
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import iis_pkg::*;

    localparam int LINE_WORDS   = 2048;
    localparam int PIPE_LATENCY = 6;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PRINT_LIMIT  = 200;

    typedef enum logic [0:0] {ROW_PIXEL, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        bit                    pinned;
        logic [SUM_W-1:0]      sum;
        logic                  last;
    } stim_row_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last;
    } pixel_result_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  pixel_valid  = 1'b0;
    logic                  pixel_stall;
    logic [15:0]           pixel_value  = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [SUM_W-1:0]      integral_sum;
    logic                  frame_last;

    // predictor state
    logic [WIDTH_W-1:0]  img_width  = WIDTH_RESET;
    logic [HEIGHT_W-1:0] img_height = HEIGHT_RESET;
    logic [SUM_W-1:0]    row_sum    = '0;
    logic [SUM_W-1:0]    line_store [LINE_WORDS];
    bit                  line_seen  [LINE_WORDS];
    int unsigned         col_pos    = 0;
    logic [ROW_W-1:0]    row_pos    = '0;

    pixel_result_t pending_sums[$];
    stim_row_t     pinned_rows[$];
    stim_row_t     directed_rows[$];

    int error_count = 0;
    int cycle_count = 0;
    bit hold_request = 1'b0;

    integral_image_stream_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .integral_sum (integral_sum),
        .frame_last   (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned eff_width(input logic [WIDTH_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > LINE_WORDS)
            return LINE_WORDS;
        return w;
    endfunction

    function automatic void advance_integral(input logic [15:0] pix,
                                             output logic [SUM_W-1:0] s,
                                             output logic last);
        int unsigned w;
        int unsigned h;
        bit end_col;
        bit end_row;
        w = eff_width(img_width);
        h = (img_height == 0) ? 1 : img_height;
        end_col = (col_pos >= w - 1);
        end_row = (row_pos >= h - 1);
        row_sum = row_sum + pix;
        s = row_sum;
        if (row_pos != 0)
            s = s + line_store[col_pos];
        line_store[col_pos] = s;
        line_seen[col_pos] = 1'b1;
        last = 1'b0;
        if (end_col)
        begin
            col_pos = 0;
            row_sum = '0;
            if (end_row)
            begin
                row_pos = '0;
                last = 1'b1;
            end
            else
                row_pos = row_pos + 1'b1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    // a wider row must never read a line store word that was never written
    function automatic bit width_fits(input logic [WIDTH_W-1:0] w);
        int unsigned n;
        n = eff_width(w);
        if (row_pos == 0)
            return 1'b1;
        for (int i = 0; i < n; i++)
            if (!line_seen[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // monitor: check results, predict accepted pixels, track register writes
    always @(posedge clk)
    begin : monitor
        logic [SUM_W-1:0] want_sum;
        logic             want_last;
        pixel_result_t    got;
        stim_row_t        pin;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_sums.size() == 0)
                    flag_error($sformatf("result transfer with nothing pending, sum %h",
                                         integral_sum));
                else
                begin
                    got = pending_sums.pop_front();
                    if (integral_sum !== got.sum)
                        flag_error($sformatf("integral_sum %h, want %h",
                                             integral_sum, got.sum));
                    if (frame_last !== got.last)
                        flag_error($sformatf("frame_last %b, want %b (sum %h)",
                                             frame_last, got.last, got.sum));
                end
            end
            if (pixel_valid && !pixel_stall)
            begin
                advance_integral(pixel_value, want_sum, want_last);
                if (pinned_rows.size() != 0)
                begin
                    pin = pinned_rows.pop_front();
                    if (pin.pinned)
                    begin
                        want_sum = pin.sum;
                        want_last = pin.last;
                    end
                end
                pending_sums.push_back('{sum: want_sum, last: want_last});
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    img_width = cfg_data[WIDTH_W-1:0];
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    img_height = cfg_data[HEIGHT_W-1:0];
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: own stall pattern, one long hold on request
    initial
    begin : result_side
        bit stalling;
        int left;
        stalling = 1'b0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    stalling = !stalling;
                    left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 30);
                end
                left--;
                result_stall <= stalling && ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic send_pixel(input logic [15:0] v);
        pixel_valid <= 1'b1;
        pixel_value <= v;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
    endtask

    // drop valid, wait for every pending result, then let the pipeline drain
    task automatic settle();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic pixel_burst(input int count, input bit steady);
        int burst_left;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (!steady && burst_left == 0)
            begin
                pixel_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 40);
            end
            send_pixel(random_pixel());
            burst_left--;
        end
    endtask

    function automatic void pix_row(input logic [15:0] v, input bit pinned,
                                    input logic [SUM_W-1:0] s, input logic last);
        directed_rows.push_back('{kind: ROW_PIXEL, reg_idx: REG_IMAGE_WIDTH, value: v,
                                  pinned: pinned, sum: s, last: last});
    endfunction

    function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        directed_rows.push_back('{kind: ROW_REG, reg_idx: idx, value: data,
                                  pinned: 1'b0, sum: '0, last: 1'b0});
    endfunction

    initial
    begin : stimulus
        int done_items;
        int n;
        bit hold_done;
        logic [WIDTH_W-1:0]    w;
        logic [CFG_DATA_W-1:0] h;

        // after reset: 640 x 480
        pix_row(16'hFFFF, 1, 32'h0000_FFFF, 0);
        pix_row(16'h0000, 1, 32'h0000_FFFF, 0);
        // width and height of zero, written mid-row
        reg_row(REG_IMAGE_WIDTH, 16'h0000);
        reg_row(REG_IMAGE_HEIGHT, 16'h0000);
        pix_row(16'h1234, 0, '0, 0);
        pix_row(16'h0000, 1, 32'h0000_0000, 1);
        pix_row(16'hFFFF, 1, 32'h0000_FFFF, 1);
        pix_row(16'hA5A5, 1, 32'h0000_A5A5, 1);
        // 3 x 2 frame
        reg_row(REG_IMAGE_WIDTH, 16'd3);
        reg_row(REG_IMAGE_HEIGHT, 16'd2);
        pix_row(16'd1, 1, 32'd1, 0);
        pix_row(16'd2, 1, 32'd3, 0);
        pix_row(16'd3, 1, 32'd6, 0);
        pix_row(16'd4, 1, 32'd5, 0);
        pix_row(16'd5, 1, 32'd12, 0);
        pix_row(16'd6, 1, 32'd21, 1);
        // widest rows, tallest frame, masked width bits
        reg_row(REG_IMAGE_WIDTH, 16'hF800);
        reg_row(REG_IMAGE_HEIGHT, 16'hFFFF);
        pix_row(16'hFFFF, 1, 32'h0000_FFFF, 0);
        pix_row(16'hFFFF, 1, 32'h0001_FFFE, 0);
        pix_row(16'h5A5A, 0, '0, 0);
        reg_row(REG_IMAGE_WIDTH, 16'h0FFF);
        pix_row(16'h0000, 0, '0, 0);
        // shrink past the current column, then make this row the last
        reg_row(REG_IMAGE_WIDTH, 16'd2);
        pix_row(16'd7, 0, '0, 0);
        reg_row(REG_IMAGE_HEIGHT, 16'd2);
        pix_row(16'd8, 0, '0, 0);
        pix_row(16'd9, 0, '0, 1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
            begin
                pinned_rows.push_back(directed_rows[i]);
                send_pixel(directed_rows[i].value);
            end
        end

        done_items = 0;
        hold_done = 1'b0;
        while (done_items < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0: w = '0;
                1: w = 12'($urandom_range(LINE_WORDS + 1, 4095));
                2: w = 12'($urandom_range(17, 200));
                default: w = 12'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 7))
                0: h = '0;
                1: h = 16'hFFFF;
                2: h = 16'($urandom());
                default: h = 16'($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 2) != 0 && width_fits(w))
                write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), w});
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_IMAGE_HEIGHT, h);
            if (!hold_done && done_items > RANDOM_ITEMS / 3)
            begin
                hold_done = 1'b1;
                hold_request = 1'b1;
                n = 60;
                pixel_burst(n, 1);
            end
            else
            begin
                n = $urandom_range(10, 90);
                pixel_burst(n, 0);
            end
            done_items += n;
        end

        settle();
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
